// ===== rtl/tmb_pkg.sv =====
// Shared types and constants for the tile-map blit address generator.
// No dependencies.
`timescale 1ns / 1ps
package tmb_pkg;
    localparam int MAX_TILESETS = 8;
    localparam int SLOT_BITS    = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;
    localparam int CNT_BITS     = 4;
    localparam int GID_BITS     = 16;
    localparam int COL_BITS     = 13;
    localparam int SZ_BITS      = 9;
    localparam int CELL_BITS    = 20;
    localparam int QC_BITS      = 20;
    localparam int COORD_BITS   = 24;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TILE = 1'b1;
    localparam logic [0:0] REG_MAP_WIDTH = 1'b0;
    localparam logic [0:0] REG_TILESET_COUNT = 1'b1;

    // one table entry
    typedef struct packed {
        logic [GID_BITS-1:0] first_gid;
        logic [COL_BITS-1:0] columns;
        logic [SZ_BITS-1:0]  tile_w;
        logic [SZ_BITS-1:0]  tile_h;
    } t_entry;

    // product saturated to coordinate width
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [41:0] v);
        sat_coord = (v > 42'(COORD_MAX)) ? COORD_MAX : v[COORD_BITS-1:0];
    endfunction
endpackage

// ===== rtl/tmb_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, divisor travels along.
// Depends on tmb_pkg.
`timescale 1ns / 1ps
module tmb_divider
    import tmb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [QC_BITS-1:0]   i_num,
    input  logic [COL_BITS-1:0]  i_den,
    output logic [QC_BITS-1:0]   o_quo,
    output logic [COL_BITS-1:0]  o_rem
);
    logic [QC_BITS-1:0]  r_q   [QC_BITS+1];
    logic [COL_BITS:0]   r_rm  [QC_BITS+1];
    logic [COL_BITS-1:0] r_d   [QC_BITS+1];

    always_comb begin
        r_q[0]  = i_num;
        r_rm[0] = '0;
        r_d[0]  = i_den;
    end

    // each stage shifts one numerator bit into the remainder
    for (genvar s = 0; s < QC_BITS; s++) begin : g_stage
        logic [COL_BITS+1:0] n_sh;
        logic                n_ge;
        always_comb begin
            n_sh = {r_rm[s], r_q[s][QC_BITS-1]};
            n_ge = n_sh >= {2'b0, r_d[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rm[s+1] <= n_ge ? (COL_BITS+1)'(n_sh - {2'b0, r_d[s]})
                                  : n_sh[COL_BITS:0];
                r_q[s+1]  <= {r_q[s][QC_BITS-2:0], n_ge};
                r_d[s+1]  <= r_d[s];
            end
        end
    end

    assign o_quo = r_q[QC_BITS];
    assign o_rem = r_rm[QC_BITS][COL_BITS-1:0];
endmodule

// ===== rtl/tmb_lookup.sv =====
// Tileset table and priority match of a tile id against first ids.
// Depends on tmb_pkg.
`timescale 1ns / 1ps
module tmb_lookup
    import tmb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [SLOT_BITS-1:0] i_wr_slot,
    input  t_entry               i_wr_entry,
    input  logic [CNT_BITS-1:0]  i_count,
    input  logic [GID_BITS-1:0]  i_gid,
    output logic                 o_found,
    output logic [SLOT_BITS-1:0] o_sel,
    output t_entry               o_entry
);
    t_entry r_tab [MAX_TILESETS];

    // table write, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TILESETS; i++) r_tab[i] <= '0;
        end else if (i_wr) begin
            r_tab[i_wr_slot] <= i_wr_entry;
        end
    end

    // highest valid slot whose first id is not above the tile id
    always_comb begin
        o_found = 1'b0;
        o_sel   = '0;
        for (int i = 0; i < MAX_TILESETS; i++) begin
            if ((CNT_BITS+1)'(i) < {1'b0, i_count} && r_tab[i].first_gid <= i_gid) begin
                o_found = 1'b1;
                o_sel   = SLOT_BITS'(i);
            end
        end
        o_entry = r_tab[o_sel];
    end
endmodule

// ===== rtl/tile_map_blit_address_gen_unit.sv =====
// Top level of the tile-map blit address generator.
// Depends on tmb_pkg, tmb_lookup, tmb_divider.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid/o_ready) takes one word per cycle. action 0 loads
//   a tileset table entry and gives no output; action 1 places a tile.
//   Tiles with id 0 or on a hidden layer give no output word.
//   Config channel (i_cfg_valid/o_cfg_ready) writes map_width (index 0) or
//   tileset_count (index 1); write only while idle.
//   Pipeline: one table lookup stage, 20 divider stages (one quotient bit
//   each, id and cell divided in parallel), one multiply stage and one
//   saturate/output stage; one word per cycle unless the receiver stalls.
//   The whole pipe advances only when the output register is free or
//   taken; when the receiver stalls, o_ready drops and nothing is lost.
//   Reset clears the table, sets map_width to 1 and tileset_count to 0,
//   and empties the pipe.
module tile_map_blit_address_gen_unit
    import tmb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [0:0]            i_cfg_index,
    input  logic [12:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [2:0]            i_entry_slot,
    input  logic [15:0]           i_new_first_gid,
    input  logic [12:0]           i_new_columns,
    input  logic [8:0]            i_new_tile_width,
    input  logic [8:0]            i_new_tile_height,
    input  logic [15:0]           i_tile_gid,
    input  logic [19:0]           i_cell_index,
    input  logic [7:0]            i_layer_alpha,
    input  logic                  i_layer_visible,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [23:0]           o_src_x,
    output logic [23:0]           o_src_y,
    output logic [23:0]           o_dst_x,
    output logic [23:0]           o_dst_y,
    output logic [8:0]            o_rect_width,
    output logic [8:0]            o_rect_height,
    output logic [2:0]            o_sheet_select,
    output logic [7:0]            o_draw_alpha,
    output logic                  o_miss
);
    localparam int DIV_LAT = QC_BITS;

    typedef struct packed {
        logic                 miss;
        logic [SLOT_BITS-1:0] sel;
        logic [SZ_BITS-1:0]   tw;
        logic [SZ_BITS-1:0]   th;
        logic [7:0]           alpha;
    } t_side;

    logic [COL_BITS-1:0] r_map_width;
    logic [CNT_BITS-1:0] r_count;
    logic                adv;

    assign o_cfg_ready = 1'b1;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= COL_BITS'(1);
            r_count     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAP_WIDTH:     r_map_width <= i_cfg_data;
                REG_TILESET_COUNT: r_count     <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // table and match
    logic                 lk_found;
    logic [SLOT_BITS-1:0] lk_sel;
    t_entry               lk_entry;
    logic [CNT_BITS-1:0]  eff_count;
    logic                 acc, is_load;

    assign acc     = i_valid && o_ready;
    assign is_load = i_action == ACT_LOAD;
    assign eff_count = (r_count > CNT_BITS'(MAX_TILESETS)) ? CNT_BITS'(MAX_TILESETS)
                                                           : r_count;

    tmb_lookup u_lookup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (acc && is_load),
        .i_wr_slot  (SLOT_BITS'(i_entry_slot)),
        .i_wr_entry ({i_new_first_gid, i_new_columns, i_new_tile_width,
                      i_new_tile_height}),
        .i_count    (eff_count),
        .i_gid      (i_tile_gid),
        .o_found    (lk_found),
        .o_sel      (lk_sel),
        .o_entry    (lk_entry)
    );

    // stage 1: register lookup result
    logic                r1_v;
    t_side               r1_side;
    logic [QC_BITS-1:0]  r1_idx, r1_cell;
    logic [COL_BITS-1:0] r1_cols, r1_mw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= acc && i_action == ACT_TILE && i_tile_gid != '0 && i_layer_visible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side.miss  <= !lk_found || lk_entry.columns == '0;
            r1_side.sel   <= lk_found ? lk_sel : '0;
            r1_side.tw    <= lk_entry.tile_w;
            r1_side.th    <= lk_entry.tile_h;
            r1_side.alpha <= i_layer_alpha;
            r1_idx  <= QC_BITS'(i_tile_gid - lk_entry.first_gid);
            r1_cols <= (lk_entry.columns == '0) ? COL_BITS'(1) : lk_entry.columns;
            r1_cell <= i_cell_index;
            r1_mw   <= (r_map_width == '0) ? COL_BITS'(1) : r_map_width;
        end
    end

    // divider stages
    logic [QC_BITS-1:0]  qi, qc;
    logic [COL_BITS-1:0] ri, rc;

    tmb_divider u_div_id (
        .i_clk(i_clk), .i_en(adv), .i_num(r1_idx), .i_den(r1_cols),
        .o_quo(qi), .o_rem(ri)
    );
    tmb_divider u_div_cell (
        .i_clk(i_clk), .i_en(adv), .i_num(r1_cell), .i_den(r1_mw),
        .o_quo(qc), .o_rem(rc)
    );

    // side data delayed alongside the dividers
    logic  r_dv [DIV_LAT];
    t_side r_ds [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_dv[i] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r1_v;
            for (int i = 1; i < DIV_LAT; i++) r_dv[i] <= r_dv[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ds[0] <= r1_side;
            for (int i = 1; i < DIV_LAT; i++) r_ds[i] <= r_ds[i-1];
        end
    end

    // multiply stage
    logic        r2_v;
    t_side       r2_side;
    logic [41:0] r2_sx, r2_sy, r2_dx, r2_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (adv) r2_v <= r_dv[DIV_LAT-1];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_side <= r_ds[DIV_LAT-1];
            r2_sx <= 42'(ri * r_ds[DIV_LAT-1].tw);
            r2_sy <= 42'(qi * r_ds[DIV_LAT-1].th);
            r2_dx <= 42'(rc * r_ds[DIV_LAT-1].tw);
            r2_dy <= 42'(qc * r_ds[DIV_LAT-1].th);
        end
    end

    // output register: saturate and zero on miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (adv) o_valid <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_miss         <= r2_side.miss;
            o_sheet_select <= 3'(r2_side.sel);
            o_draw_alpha   <= r2_side.alpha;
            o_src_x        <= r2_side.miss ? '0 : sat_coord(r2_sx);
            o_src_y        <= r2_side.miss ? '0 : sat_coord(r2_sy);
            o_dst_x        <= r2_side.miss ? '0 : sat_coord(r2_dx);
            o_dst_y        <= r2_side.miss ? '0 : sat_coord(r2_dy);
            o_rect_width   <= r2_side.miss ? '0 : r2_side.tw;
            o_rect_height  <= r2_side.miss ? '0 : r2_side.th;
        end
    end
endmodule

// ===== tb/sv/tile_map_blit_address_gen_unit_tb.sv =====
// Self-checking bench for tile_map_blit_address_gen_unit: directed table, then random
// tile and tileset loads under four idle/stall phases. Depends on tmb_pkg and the RTL.
`timescale 1ns / 1ps
module tile_map_blit_address_gen_unit_tb
    import tmb_pkg::*;
;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {ROW_WORD, ROW_CFG} t_row_kind;

    // one input word
    typedef struct {
        logic        action;
        logic [2:0]  slot;
        logic [15:0] fgid;
        logic [12:0] cols;
        logic [8:0]  tw;
        logic [8:0]  th;
        logic [15:0] gid;
        logic [19:0] cell_idx;
        logic [7:0]  alpha;
        logic        vis;
    } t_word;

    // one blit rectangle word
    typedef struct packed {
        logic [23:0] src_x;
        logic [23:0] src_y;
        logic [23:0] dst_x;
        logic [23:0] dst_y;
        logic [8:0]  rw;
        logic [8:0]  rh;
        logic [2:0]  sel;
        logic [7:0]  alpha;
        logic        miss;
    } t_blit;

    // directed row: a word or a register write, with an optional typed-in result
    typedef struct {
        t_row_kind   kind;
        t_word       w;
        logic [0:0]  reg_idx;
        logic [12:0] reg_val;
        bit          typed;
        t_blit       res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [2:0]  i_entry_slot = '0;
    logic [15:0] i_new_first_gid = '0;
    logic [12:0] i_new_columns = '0;
    logic [8:0]  i_new_tile_width = '0;
    logic [8:0]  i_new_tile_height = '0;
    logic [15:0] i_tile_gid = '0;
    logic [19:0] i_cell_index = '0;
    logic [7:0]  i_layer_alpha = '0;
    logic        i_layer_visible = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [23:0] o_src_x, o_src_y, o_dst_x, o_dst_y;
    logic [8:0]  o_rect_width, o_rect_height;
    logic [2:0]  o_sheet_select;
    logic [7:0]  o_draw_alpha;
    logic        o_miss;

    tile_map_blit_address_gen_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    t_entry      tset [MAX_TILESETS];
    logic [12:0] map_w;
    logic [3:0]  tset_count;

    t_blit blit_q[$];
    bit    typed_pending = 1'b0;
    t_blit typed_res = '0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    n_err = 0;
    int    n_words = 0;
    int    n_blits = 0;
    int    n_cfg = 0;
    int    cycles = 0;

    function automatic logic [23:0] sat24(input longint unsigned v);
        return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endfunction

    // apply one word to the table; returns 1 if it yields a blit word
    function automatic bit blit_predict(input t_word w, output t_blit r);
        int unsigned     n;
        int unsigned     sel;
        bit              hit;
        longint unsigned idx, cols, tw, th, mw;
        r = '0;
        if (w.action == ACT_LOAD) begin
            tset[w.slot] = '{first_gid: w.fgid, columns: w.cols, tile_w: w.tw, tile_h: w.th};
            return 0;
        end
        if (w.gid == 0 || !w.vis) return 0;
        n = (tset_count > MAX_TILESETS) ? MAX_TILESETS : tset_count;
        hit = 0;
        sel = 0;
        for (int i = 0; i < n; i++)
            if (tset[i].first_gid <= w.gid) begin
                hit = 1;
                sel = i;
            end
        r.alpha = w.alpha;
        if (!hit) begin
            r.miss = 1'b1;
            return 1;
        end
        r.sel = sel[2:0];
        cols = tset[sel].columns;
        if (cols == 0) begin
            r.miss = 1'b1;
            return 1;
        end
        idx = w.gid - tset[sel].first_gid;
        tw = tset[sel].tile_w;
        th = tset[sel].tile_h;
        mw = (map_w == 0) ? 1 : map_w;
        r.src_x = sat24((idx % cols) * tw);
        r.src_y = sat24((idx / cols) * th);
        r.dst_x = sat24((w.cell_idx % mw) * tw);
        r.dst_y = sat24((w.cell_idx / mw) * th);
        r.rw = tw[8:0];
        r.rh = th[8:0];
        return 1;
    endfunction

    // monitor: predict on accepted words, check on delivered words
    always @(posedge i_clk) begin
        t_word w;
        t_blit r, got, want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_MAP_WIDTH) map_w = i_cfg_data;
                else tset_count = i_cfg_data[3:0];
                n_cfg++;
            end
            if (i_valid && o_ready) begin
                w = '{i_action, i_entry_slot, i_new_first_gid, i_new_columns,
                      i_new_tile_width, i_new_tile_height, i_tile_gid, i_cell_index,
                      i_layer_alpha, i_layer_visible};
                n_words++;
                if (blit_predict(w, r)) blit_q = {blit_q, (typed_pending ? typed_res : r)};
            end
            if (o_valid && i_ready) begin
                got = '{o_src_x, o_src_y, o_dst_x, o_dst_y, o_rect_width, o_rect_height,
                        o_sheet_select, o_draw_alpha, o_miss};
                n_blits++;
                if (blit_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("ERROR: unexpected word %p", got);
                end else begin
                    want = blit_q.pop_front();
                    if (got.src_x != want.src_x || got.src_y != want.src_y ||
                        got.dst_x != want.dst_x || got.dst_y != want.dst_y ||
                        got.rw != want.rw || got.rh != want.rh || got.sel != want.sel ||
                        got.alpha != want.alpha || got.miss != want.miss) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("ERROR: word %0d mismatch\n  exp %p\n  got %p",
                                     n_blits, want, got);
                    end
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    // send one word, with random idle cycles ahead of it
    task automatic put_word(input t_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_action <= w.action;
        i_entry_slot <= w.slot;
        i_new_first_gid <= w.fgid;
        i_new_columns <= w.cols;
        i_new_tile_width <= w.tw;
        i_new_tile_height <= w.th;
        i_tile_gid <= w.gid;
        i_cell_index <= w.cell_idx;
        i_layer_alpha <= w.alpha;
        i_layer_visible <= w.vis;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // register write once the pipe has drained
    task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (blit_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_word load_w(input int slot, input int fg, input int c,
                                     input int tw, input int th);
        t_word w = '{default: '0};
        w.action = ACT_LOAD;
        w.slot = 3'(slot);
        w.fgid = 16'(fg);
        w.cols = 13'(c);
        w.tw = 9'(tw);
        w.th = 9'(th);
        return w;
    endfunction

    function automatic t_word tile_w(input int gid, input int cell_pos, input int a,
                                     input bit v);
        t_word w = '{default: '0};
        w.action = ACT_TILE;
        w.gid = 16'(gid);
        w.cell_idx = 20'(cell_pos);
        w.alpha = 8'(a);
        w.vis = v;
        return w;
    endfunction

    function automatic t_row wrow(input t_word w);
        return '{ROW_WORD, w, 1'b0, 13'd0, 1'b0, '0};
    endfunction

    function automatic t_row crow(input logic [0:0] idx, input int val);
        return '{ROW_CFG, '{default: '0}, idx, 13'(val), 1'b0, '0};
    endfunction

    function automatic t_row trow(input t_word w, input t_blit r);
        return '{ROW_WORD, w, 1'b0, 13'd0, 1'b1, r};
    endfunction

    // random word: mostly tiles near the loaded first ids, some loads and noise
    function automatic t_word rand_word();
        t_word w;
        int    k;
        w.action = ($urandom_range(99) < 25) ? ACT_LOAD : ACT_TILE;
        w.slot = 3'($urandom_range(7));
        k = $urandom_range(99);
        if (k < 60) w.fgid = 16'(w.slot * 64 + $urandom_range(1, 63));
        else if (k < 70) w.fgid = 16'd0;
        else w.fgid = 16'($urandom);
        w.cols = ($urandom_range(9) == 0) ? 13'd0 :
                 ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(1, 16));
        w.tw = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 32));
        w.th = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 32));
        k = $urandom_range(99);
        if (k < 5) w.gid = 16'd0;
        else if (k < 75) w.gid = 16'($urandom_range(1, 600));
        else w.gid = 16'($urandom);
        w.cell_idx = ($urandom_range(1) == 0) ? 20'($urandom_range(4095)) : 20'($urandom);
        w.alpha = 8'($urandom);
        w.vis = ($urandom_range(9) != 0);
        return w;
    endfunction

    function automatic logic [12:0] rand_map_w();
        int k = $urandom_range(9);
        if (k == 0) return 13'd0;
        if (k == 1) return 13'h1FFF;
        if (k < 6) return 13'($urandom_range(1, 16));
        return 13'($urandom);
    endfunction

    t_row dir_rows[$];

    // append one directed row
    function automatic void add_row(input t_row r);
        dir_rows = {dir_rows, r};
    endfunction

    initial begin
        t_blit b;
        for (int i = 0; i < MAX_TILESETS; i++) tset[i] = '0;
        map_w = 13'd1;
        tset_count = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed-in results where they are plain to read
        b = '0; b.alpha = 8'd255; b.miss = 1'b1;
        add_row(trow(tile_w(1, 0, 255, 1), b));  // empty table misses
        add_row(wrow(tile_w(0, 3, 7, 1)));       // empty cell
        add_row(wrow(tile_w(7, 3, 7, 0)));       // hidden layer
        add_row(crow(REG_TILESET_COUNT, 3));
        add_row(crow(REG_MAP_WIDTH, 4096));
        add_row(wrow(load_w(0, 1, 8, 16, 16)));
        add_row(wrow(load_w(1, 100, 0, 8, 8)));
        add_row(wrow(load_w(2, 65535, 8191, 511, 511)));
        b = '0; b.rw = 9'd16; b.rh = 9'd16;
        add_row(trow(tile_w(1, 0, 0, 1), b));
        b = '0; b.sel = 3'd1; b.alpha = 8'd9; b.miss = 1'b1;      // zero sheet columns
        add_row(trow(tile_w(150, 5, 9, 1), b));
        b = '0; b.dst_x = 24'd2092545; b.dst_y = 24'd130305;
        b.rw = 9'd511; b.rh = 9'd511; b.sel = 3'd2; b.alpha = 8'd255;
        add_row(trow(tile_w(65535, 20'hFFFFF, 255, 1), b));
        add_row(wrow(tile_w(99, 4097, 128, 1)));
        add_row(crow(REG_MAP_WIDTH, 0));         // zero width acts as one
        b = '0; b.dst_y = 24'hFFFFFF; b.rw = 9'd511; b.rh = 9'd511; b.sel = 3'd2;
        b.alpha = 8'd1;
        add_row(trow(tile_w(65535, 20'hFFFFF, 1, 1), b));  // saturation
        add_row(crow(REG_TILESET_COUNT, 15));    // clamps to table size
        b = '0; b.sel = 3'd7; b.alpha = 8'd3; b.miss = 1'b1;
        add_row(trow(tile_w(3, 0, 3, 1), b));
        add_row(wrow(load_w(7, 0, 1, 0, 0)));    // zero tile size
        b = '0; b.sel = 3'd7; b.alpha = 8'd4;
        add_row(trow(tile_w(4, 77, 4, 1), b));
        add_row(wrow(load_w(7, 65535, 8191, 511, 511)));
        add_row(wrow(tile_w(65535, 12345, 170, 1)));
        add_row(wrow(tile_w(65534, 54321, 85, 1)));
        add_row(wrow(load_w(5, 200, 3, 5, 7)));  // unsorted slot
        add_row(wrow(tile_w(60000, 999, 17, 1)));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                // typed-in result travels with the word it belongs to
                typed_pending <= dir_rows[i].typed;
                typed_res <= dir_rows[i].res;
                put_word(dir_rows[i].w);
            end
        end

        // random part: four idle/stall phases, registers changed between chunks
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 71) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 71) : 0;
            for (int c = 0; c < 6; c++) begin
                write_reg(REG_MAP_WIDTH, rand_map_w());
                write_reg(REG_TILESET_COUNT, 13'((c == 0) ? 0 : (c == 1) ? 8 :
                          ($urandom_range(4) == 0) ? $urandom_range(15) :
                                                     $urandom_range(1, 8)));
                repeat (60) put_word(rand_word());
                if (c == 2) begin
                    // stretch without gaps inside a stalled phase
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            end
        end
        i_valid <= 1'b0;
        while (blit_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d input words, %0d blit words, %0d register writes.",
                 n_words, n_blits, n_cfg);
        $display("Phases: free-running, sender gaps, receiver stalls, both.");
        if (n_err == 0 && blit_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d words still expected", n_err, blit_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    // run watchdog
    always @(posedge i_clk)
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
endmodule
